// ===== hdl/scot_pkg.sv =====
// ----------------------------------------------------------------------------
// Sine/cosine octant table package
// Shared constants, the octant code and the elaboration-time functions that
// build the first-octant cosine/sine samples.
// ----------------------------------------------------------------------------
package scot_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 64;
  localparam int unsigned OUT_FRAC_BITS_DEF = 16;

  localparam int unsigned PHASE_W = 16;
  localparam int unsigned REM_W   = 13;
  localparam int unsigned OCT_W   = 2;
  localparam int unsigned OUT_W   = 18;

  localparam logic [REM_W-1:0] REM_MASK = {REM_W{1'b1}};

  // pi with 29 and 30 fraction bits, rounded.
  localparam longint unsigned PI_Q29  = 64'd1686629713;
  localparam longint unsigned PI_Q30  = 64'd3373259426;
  localparam longint unsigned ONE_Q30 = 64'd1 << 30;

  typedef enum logic [OCT_W-1:0] {
    OCT_FIRST  = 2'd0,
    OCT_SECOND = 2'd1,
    OCT_THIRD  = 2'd2,
    OCT_FOURTH = 2'd3
  } octant_e;

  // Shift-and-subtract division for the series coefficients.
  function automatic longint unsigned udiv_u64(longint unsigned num,
                                               longint unsigned den);
    longint unsigned quo;
    longint unsigned part;
    quo  = '0;
    part = '0;
    for (int i = 63; i >= 0; i--) begin
      part = {part[62:0], num[i]};
      if (part >= den) begin
        part   = part - den;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Taylor series of sin (odd set) or cos of x in Q30, x below 1.
  // Only evaluated at elaboration to fill the sample table.
  function automatic longint unsigned series_q30(longint unsigned x, bit odd);
    longint unsigned term;
    longint unsigned sum;
    longint unsigned dv;
    longint unsigned n;
    term = odd ? x : ONE_Q30;
    sum  = term;
    n    = odd ? 64'd1 : 64'd0;
    for (int k = 1; k < 12; k++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      dv   = (n + 64'd1) * (n + 64'd2);
      term = udiv_u64(term, dv);
      n    = n + 64'd2;
      if (k[0]) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return sum;
  endfunction

  // Round half up from Q30 to the output fraction width.
  function automatic longint unsigned q30_to_out(longint unsigned v, int unsigned frac);
    int unsigned sh;
    sh = 30 - frac;
    return (v + (64'd1 << (sh - 1))) >> sh;
  endfunction

endpackage

// ===== hdl/sine_cosine_octant_table_top.sv =====
// An accepted phase word is registered in each stage in turn and leaves as its result word.
// Throughput: one word per cycle while the output is not stalled; each of the five
// stages holds one word and moves it on when the next stage is empty or moving, so
// bubbles close up. The sample table is constant logic read in the first stage;
// there is no fill or clearing pass, and reset (rst_ni, asynchronous, active low)
// only clears the stage valid bits.
// ----------------------------------------------------------------------------
// Sine/cosine octant table
// Cosine and sine of a 16-bit phase from a first-octant sample table with
// first-order interpolation, octant folding and saturation.
// ----------------------------------------------------------------------------
module sine_cosine_octant_table_top #(
  parameter int unsigned TABLE_ENTRIES = scot_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned OUT_FRAC_BITS = scot_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [scot_pkg::PHASE_W-1:0]        phase_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [scot_pkg::OUT_W-1:0]   cos_value_o,
  output logic signed [scot_pkg::OUT_W-1:0]   sin_value_o
);

  // TABLE_ENTRIES is a power of two.
  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
  localparam int unsigned HB    = scot_pkg::REM_W - IDX_W;
  localparam int unsigned CW    = OUT_FRAC_BITS + 1;
  localparam int unsigned PW    = HB + CW;
  localparam int unsigned SW    = CW + 2;
  localparam longint unsigned DEN = 64'(4 * TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] IDX_MASK = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic signed [SW-1:0] LIM = SW'(1) <<< OUT_FRAC_BITS;

  // --------------------------------------------------------------------------
  // Constant sample table
  // --------------------------------------------------------------------------
  logic [CW-1:0] rom_cos [TABLE_ENTRIES];
  logic [CW-1:0] rom_sin [TABLE_ENTRIES];

  for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_rom
    localparam longint unsigned XQ30 =
      (64'(k) * scot_pkg::PI_Q30 + DEN / 2) / DEN;
    assign rom_cos[k] =
      CW'(scot_pkg::q30_to_out(scot_pkg::series_q30(XQ30, 1'b0), OUT_FRAC_BITS));
    assign rom_sin[k] =
      CW'(scot_pkg::q30_to_out(scot_pkg::series_q30(XQ30, 1'b1), OUT_FRAC_BITS));
  end

  // --------------------------------------------------------------------------
  // Stage enables: a stage loads when it is empty or its contents move on.
  // --------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q, out_valid_q;
  logic en1, en2, en3, en4, en5;

  assign en5 = !out_valid_q || !out_stall_i;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign in_stall_o  = !en1;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) out_valid_q <= v4_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: octant decode, odd-octant mirror and table read
  // --------------------------------------------------------------------------
  logic [scot_pkg::REM_W-1:0] rem, rem_m;
  logic [scot_pkg::OCT_W-1:0] oct, oct_eff;
  logic                       neg;
  logic [IDX_W-1:0]           tidx;

  assign rem     = phase_i[scot_pkg::REM_W-1:0];
  assign oct     = phase_i[scot_pkg::REM_W +: scot_pkg::OCT_W];
  assign neg     = phase_i[scot_pkg::PHASE_W-1];
  assign rem_m   = oct[0] ? (scot_pkg::REM_MASK - rem) : rem;
  assign tidx    = rem_m[scot_pkg::REM_W-1 -: IDX_W] & IDX_MASK;
  // A negative phase runs through the octants in reverse order.
  assign oct_eff = neg ? ~oct : oct;

  logic [CW-1:0]              ck1_q, sk1_q;
  logic [HB-1:0]              h1_q;
  scot_pkg::octant_e          oct1_q;
  logic                       neg1_q;

  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      ck1_q  <= rom_cos[tidx];
      sk1_q  <= rom_sin[tidx];
      h1_q   <= rem_m[HB-1:0];
      oct1_q <= scot_pkg::octant_e'(oct_eff);
      neg1_q <= neg;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: fine step times sample
  // --------------------------------------------------------------------------
  logic [PW-1:0]     pc2_q, ps2_q;
  logic [CW-1:0]     ck2_q, sk2_q;
  scot_pkg::octant_e oct2_q;
  logic              neg2_q;

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      pc2_q  <= PW'(h1_q) * PW'(ck1_q);
      ps2_q  <= PW'(h1_q) * PW'(sk1_q);
      ck2_q  <= ck1_q;
      sk2_q  <= sk1_q;
      oct2_q <= oct1_q;
      neg2_q <= neg1_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: scale by pi (the product wraps at 64 bits)
  // --------------------------------------------------------------------------
  logic [63:0]       mc3_q, ms3_q;
  logic [CW-1:0]     ck3_q, sk3_q;
  scot_pkg::octant_e oct3_q;
  logic              neg3_q;

  always_ff @(posedge clk_i) begin
    if (en3 && v2_q) begin
      mc3_q  <= 64'(pc2_q) * scot_pkg::PI_Q29;
      ms3_q  <= 64'(ps2_q) * scot_pkg::PI_Q29;
      ck3_q  <= ck2_q;
      sk3_q  <= sk2_q;
      oct3_q <= oct2_q;
      neg3_q <= neg2_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: round the correction terms and interpolate
  // --------------------------------------------------------------------------
  logic [63:0]       rc, rs;
  logic [CW-1:0]     term_c, term_s;
  logic signed [SW-1:0] s1_d, c1_d;

  assign rc     = (mc3_q + (64'd1 << 43)) >> 44;
  assign rs     = (ms3_q + (64'd1 << 43)) >> 44;
  // The correction stays below the sample it scales, so CW bits suffice.
  assign term_c = rc[CW-1:0];
  assign term_s = rs[CW-1:0];
  assign s1_d   = $signed(SW'(sk3_q)) + $signed(SW'(term_c));
  assign c1_d   = $signed(SW'(ck3_q)) - $signed(SW'(term_s));

  logic signed [SW-1:0] s14_q, c14_q;
  scot_pkg::octant_e    oct4_q;
  logic                 neg4_q;

  always_ff @(posedge clk_i) begin
    if (en4 && v3_q) begin
      s14_q  <= s1_d;
      c14_q  <= c1_d;
      oct4_q <= oct3_q;
      neg4_q <= neg3_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: octant swap and negate, sign, saturate
  // --------------------------------------------------------------------------
  logic signed [SW-1:0] so_pre, so, co;
  logic signed [SW-1:0] so_sat, co_sat;

  always_comb begin
    case (oct4_q)
      scot_pkg::OCT_FIRST: begin
        so_pre = s14_q;
        co     = c14_q;
      end
      scot_pkg::OCT_SECOND: begin
        so_pre = c14_q;
        co     = s14_q;
      end
      scot_pkg::OCT_THIRD: begin
        so_pre = c14_q;
        co     = -s14_q;
      end
      default: begin
        so_pre = s14_q;
        co     = -c14_q;
      end
    endcase
    so = neg4_q ? -so_pre : so_pre;

    if (so > LIM) begin
      so_sat = LIM;
    end else if (so < -LIM) begin
      so_sat = -LIM;
    end else begin
      so_sat = so;
    end

    if (co > LIM) begin
      co_sat = LIM;
    end else if (co < -LIM) begin
      co_sat = -LIM;
    end else begin
      co_sat = co;
    end
  end

  logic signed [scot_pkg::OUT_W-1:0] cos_q, sin_q;

  always_ff @(posedge clk_i) begin
    if (en5 && v4_q) begin
      cos_q <= scot_pkg::OUT_W'(co_sat);
      sin_q <= scot_pkg::OUT_W'(so_sat);
    end
  end

  assign cos_value_o = cos_q;
  assign sin_value_o = sin_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  localparam int OUT_LIM = 1 << OUT_FRAC_BITS;

  // Backpressure upstream only ever comes from a full, stalled output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a stalled output word");

  // With no output stall, an accepted word moves through v1_q to v4_q and shows up as a valid output word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !out_stall_i) ##1 !out_stall_i ##1 !out_stall_i
      ##1 !out_stall_i ##1 !out_stall_i |=> out_valid_o)
    else $error("accepted word did not reach the output in five cycles");

  // Results never leave the range of plus or minus one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (OUT_FRAC_BITS > scot_pkg::OUT_W - 2) ||
      (int'(cos_value_o) <= OUT_LIM && int'(cos_value_o) >= -OUT_LIM))
    else $error("cosine word out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (OUT_FRAC_BITS > scot_pkg::OUT_W - 2) ||
      (int'(sin_value_o) <= OUT_LIM && int'(sin_value_o) >= -OUT_LIM))
    else $error("sine word out of range");

endmodule
